/* hdl/bounded_xorshift_roll_core_defines.svh */
// Assertion macros for the bounded xorshift roll core checker.
`ifndef BOUNDED_XORSHIFT_ROLL_CORE_DEFINES_SVH
`define BOUNDED_XORSHIFT_ROLL_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BXR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BXR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bxr_pkg.sv */
// Shared types, constants and the generator step function for the roll core.
package bxr_pkg;

  localparam int unsigned GenW   = 32;
  localparam int unsigned BoundW = 31;
  localparam int unsigned CntW   = $clog2(GenW);

  localparam logic [GenW-1:0] SeedReset = 32'd1;
  localparam logic [GenW-1:0] Full      = 32'hFFFF_FFFF;

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LIMIT,
    ST_DRAW,
    ST_MOD,
    ST_FINISH
  } bxr_state_e;

  typedef struct packed {
    logic idle;
    logic load_bound;
    logic div_start;
    logic div_from_draw;
    logic load_limit;
    logic step_gen;
    logic out_load;
  } bxr_cmd_t;

  typedef struct packed {
    logic bound_zero;
    logic div_busy;
    logic draw_ok;
    logic out_free;
  } bxr_sts_t;

  function automatic logic [GenW-1:0] xorshift(input logic [GenW-1:0] s);
    logic [GenW-1:0] t;
    t = s ^ (s << ShiftA);
    t = t ^ (t >> ShiftB);
    t = t ^ (t << ShiftC);
    return t;
  endfunction

endpackage

/* hdl/bxr_div.sv */
// Restoring remainder unit: one quotient bit per cycle, 32-bit dividend, 31-bit divisor.
module bxr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bxr_pkg::GenW-1:0]    dividend_i,
  input  logic [bxr_pkg::BoundW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [bxr_pkg::BoundW-1:0]  rem_o
);

  logic                        busy_q, busy_d;
  logic [bxr_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [bxr_pkg::GenW-1:0]    dvd_q, dvd_d;
  logic [bxr_pkg::BoundW-1:0]  rem_q, rem_d;
  logic [bxr_pkg::GenW-1:0]    trial;
  logic [bxr_pkg::GenW-1:0]    dsr_ext;
  logic [bxr_pkg::GenW-1:0]    diff;

  assign trial   = {rem_q, dvd_q[bxr_pkg::GenW-1]};
  assign dsr_ext = {1'b0, divisor_i};
  assign diff    = trial - dsr_ext;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[bxr_pkg::GenW-2:0], 1'b0};
      if (trial >= dsr_ext) begin
        rem_d = diff[bxr_pkg::BoundW-1:0];
      end else begin
        rem_d = trial[bxr_pkg::BoundW-1:0];
      end
      if (cnt_q == '1) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/bxr_ctrl.sv */
// Controller state machine sequencing bound check, limit division, draws and final modulo.
module bxr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bxr_pkg::bxr_sts_t sts_i,
  output bxr_pkg::bxr_cmd_t cmd_o
);

  bxr_pkg::bxr_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bxr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bxr_pkg::ST_CHECK;
      end
      bxr_pkg::ST_CHECK: begin
        state_d = sts_i.bound_zero ? bxr_pkg::ST_FINISH : bxr_pkg::ST_LIMIT;
      end
      bxr_pkg::ST_LIMIT: begin
        if (!sts_i.div_busy) state_d = bxr_pkg::ST_DRAW;
      end
      bxr_pkg::ST_DRAW: begin
        if (sts_i.draw_ok) state_d = bxr_pkg::ST_MOD;
      end
      bxr_pkg::ST_MOD: begin
        if (!sts_i.div_busy) state_d = bxr_pkg::ST_FINISH;
      end
      bxr_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = bxr_pkg::ST_IDLE;
      end
      default: state_d = bxr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bxr_pkg::ST_IDLE: begin
        cmd_o.idle       = 1'b1;
        cmd_o.load_bound = in_valid_i;
      end
      bxr_pkg::ST_CHECK: begin
        cmd_o.div_start = !sts_i.bound_zero;
      end
      bxr_pkg::ST_LIMIT: begin
        cmd_o.load_limit = !sts_i.div_busy;
      end
      bxr_pkg::ST_DRAW: begin
        cmd_o.step_gen      = 1'b1;
        cmd_o.div_from_draw = 1'b1;
        cmd_o.div_start     = sts_i.draw_ok;
      end
      bxr_pkg::ST_MOD: begin
        cmd_o.div_from_draw = 1'b1;
      end
      bxr_pkg::ST_FINISH: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bxr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/bxr_dp.sv */
// Datapath: generator state, bound and limit registers, remainder unit and output register.
module bxr_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bxr_pkg::bxr_cmd_t           cmd_i,
  output bxr_pkg::bxr_sts_t           sts_o,
  input  logic                        cfg_valid_i,
  input  logic [bxr_pkg::GenW-1:0]    seed_i,
  input  logic [bxr_pkg::BoundW-1:0]  upper_bound_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bxr_pkg::BoundW-1:0]  value_o,
  output logic                        range_error_o
);

  logic [bxr_pkg::GenW-1:0]    gen_q, gen_d;
  logic [bxr_pkg::GenW-1:0]    gen_next;
  logic [bxr_pkg::BoundW-1:0]  bound_q, bound_d;
  logic [bxr_pkg::GenW-1:0]    limit_q, limit_d;
  logic [bxr_pkg::GenW-1:0]    dividend;
  logic                        div_busy;
  logic [bxr_pkg::BoundW-1:0]  rem;
  logic                        bound_zero;
  logic                        out_valid_q, out_valid_d;
  logic [bxr_pkg::BoundW-1:0]  value_q, value_d;
  logic                        err_q, err_d;

  assign gen_next   = bxr_pkg::xorshift(gen_q);
  assign bound_zero = (bound_q == '0);
  assign dividend   = cmd_i.div_from_draw ? (gen_next - 1'b1) : bxr_pkg::Full;

  bxr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (bound_q),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  always_comb begin
    gen_d = gen_q;
    if (cfg_valid_i && cmd_i.idle) begin
      gen_d = seed_i;
    end else if (cmd_i.step_gen) begin
      gen_d = gen_next;
    end
  end

  assign bound_d = cmd_i.load_bound ? upper_bound_i : bound_q;
  assign limit_d = cmd_i.load_limit ? ~{1'b0, rem} : limit_q;

  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    err_d       = err_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      err_d       = bound_zero;
      value_d     = bound_zero ? '0 : rem + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= bxr_pkg::SeedReset;
      out_valid_q <= 1'b0;
    end else begin
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    limit_q <= limit_d;
    value_q <= value_d;
    err_q   <= err_d;
  end

  assign sts_o.bound_zero = bound_zero;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.draw_ok    = (gen_next <= limit_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign range_error_o = err_q;

endmodule

/* hdl/bounded_xorshift_roll_core.sv */
// Bounded xorshift roll core: top level joining controller and datapath.
// Returns a uniform draw from 1 to upper_bound from a 32-bit xorshift (13, 17, 5)
// generator, with rejection of raw values above the largest multiple of the bound.
// One request is handled at a time. A zero bound goes from the check state
// straight to the finish state and answers with range_error set and value 0,
// the generator untouched. Any other bound runs the shared one-bit-per-cycle
// remainder unit twice (limit, then the final modulo), with the draw state in
// between stepping the generator once more for each rejected draw.
// The result sits in an output register, so a new request is taken while the
// previous result still waits. Seed writes are taken only while idle and load the
// generator directly; after reset the generator holds 1.
module bounded_xorshift_roll_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bxr_pkg::BoundW-1:0]  upper_bound_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bxr_pkg::BoundW-1:0]  value_o,
  output logic                        range_error_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bxr_pkg::GenW-1:0]    seed_i
);

  bxr_pkg::bxr_cmd_t cmd;
  bxr_pkg::bxr_sts_t sts;

  bxr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bxr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .seed_i        (seed_i),
    .upper_bound_i (upper_bound_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .range_error_o (range_error_o)
  );

  assign in_ready_o  = cmd.idle;
  assign cfg_ready_o = cmd.idle;

endmodule

/* hdl/bxr_checker.sv */
// Port-level checker for the roll core, bound to the top level.
`include "bounded_xorshift_roll_core_defines.svh"

module bxr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bxr_pkg::BoundW-1:0]  value_o,
  input logic                        range_error_o,
  input logic                        cfg_ready_o
);

  `BXR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `BXR_ASSERT_NOW(a_err_zero, out_valid_o && range_error_o, value_o == '0, "error result not zero")
  `BXR_ASSERT_NOW(a_roll_nonzero, out_valid_o && !range_error_o, value_o != '0, "roll returned zero")
  `BXR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o && !cfg_ready_o, "ready after transaction")

endmodule

bind bounded_xorshift_roll_core bxr_checker u_bxr_checker (.*);
